// ----- rtl/core/bbmf_pkg.sv -----
// Shared constants of the box blur mean filter: limits, register map and reset values.
`default_nettype none
package bbmf_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_RADIUS = 7;
    localparam int HEIGHT_LIMIT       = 1024;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int WIDTH_W    = 11;
    localparam int RADIUS_W   = 3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd800;
    localparam logic [WIDTH_W-1:0]  RST_HEIGHT = 11'd600;
    localparam logic [RADIUS_W-1:0] RST_RADIUS = 3'd1;

    localparam int COORD_W = 10;
    localparam int CHAN_W  = 8;

endpackage
`default_nettype wire

// ----- rtl/core/bbmf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bbmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/box_blur_mean_filter.sv -----
// Top level of the RGB box blur mean filter: line store, column sums and divider.
`default_nettype none
// Box blur mean filter. Pixels enter in raster order on the pixel request channel;
// red, green and blue (bits 23:16, 15:8, 7:0) are averaged over a square window of
// side n = 2k+1 and the sum is divided by n*n with truncation. A result request is
// sent only for centres whose column and row lie in [n, dimension-n), when the
// window's bottom-right pixel arrives; it carries the centre and a last-of-frame
// mark. The last 2k rows live in a line store RAM and the per-column sums of those
// rows in a column-sum RAM; each pixel passes a read state followed by a
// read-modify-write state. A pixel that yields a result then goes through the
// bit-serial divider, which handles the three channels side by side, and an
// output load state that waits while the previous result is still held. The
// result register lets the next pixel in while a result waits. Any valid
// configuration write restarts the frame at row 0, column 0; write only while the
// block is idle. Width 0 acts as 1, width above MAX_WIDTH saturates, height
// saturates at 1024, radius saturates at MAX_RADIUS.
module box_blur_mean_filter
    import bbmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // pixel requests
    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire logic [31:0]           pixel,
    // result requests
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic      [CHAN_W-1:0]     red_mean,
    output logic      [CHAN_W-1:0]     green_mean,
    output logic      [CHAN_W-1:0]     blue_mean,
    output logic      [COORD_W-1:0]    center_x,
    output logic      [COORD_W-1:0]    center_y,
    output logic                       last
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WEW   = XW + 1;
    localparam int YW    = $clog2(HEIGHT_LIMIT);
    localparam int KW    = $clog2(MAX_RADIUS + 1);
    localparam int NW    = KW + 1;
    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int RSW   = $clog2(RING);
    localparam int SLOTW = $clog2(2 * MAX_RADIUS);
    localparam int CSW   = $clog2(RING * 255 + 1);
    localparam int WSW   = $clog2(RING * RING * 255 + 1);
    localparam int AW    = 2 * NW;
    localparam int DW    = WSW + CHAN_W;
    localparam int LSD   = 2 * MAX_RADIUS * MAX_WIDTH;
    localparam int LSAW  = $clog2(LSD);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // ---------------- configuration registers ----------------
    logic [WIDTH_W-1:0]  cfg_width_reg;
    logic [WIDTH_W-1:0]  cfg_height_reg;
    logic [RADIUS_W-1:0] cfg_radius_reg;
    logic                cfg_wr;
    logic                cfg_hit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = CFG_DATA_W'(cfg_width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(cfg_height_reg);
            REG_RADIUS: prdata = CFG_DATA_W'(cfg_radius_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        unique case (paddr[3:2]) inside
            REG_WIDTH, REG_HEIGHT, REG_RADIUS: cfg_hit = cfg_wr;
            default:                           cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= RST_WIDTH;
            cfg_height_reg <= RST_HEIGHT;
            cfg_radius_reg <= RST_RADIUS;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  cfg_width_reg  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: cfg_height_reg <= pwdata[WIDTH_W-1:0];
                REG_RADIUS: cfg_radius_reg <= pwdata[RADIUS_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective (saturated) geometry
    logic [WEW-1:0] w_eff;
    logic [YW:0]    h_eff;
    logic [KW-1:0]  k_eff;
    logic [NW-1:0]  span;
    logic [NW-1:0]  n_val;

    always_comb
    begin
        if (cfg_width_reg == '0)
            w_eff = WEW'(1);
        else if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
            w_eff = WEW'(MAX_WIDTH);
        else
            w_eff = WEW'(cfg_width_reg);

        if (cfg_height_reg == '0)
            h_eff = (YW + 1)'(1);
        else if (32'(cfg_height_reg) > 32'(HEIGHT_LIMIT))
            h_eff = (YW + 1)'(HEIGHT_LIMIT);
        else
            h_eff = (YW + 1)'(cfg_height_reg);

        if (32'(cfg_radius_reg) > 32'(MAX_RADIUS))
            k_eff = KW'(MAX_RADIUS);
        else
            k_eff = KW'(cfg_radius_reg);
    end

    assign span  = {k_eff, 1'b0};
    assign n_val = span + NW'(1);

    // ---------------- control state ----------------
    logic [1:0]       state_reg, state_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [YW-1:0]    y_reg, y_next;
    logic [RSW-1:0]   rs_reg, rs_next;
    logic [SLOTW-1:0] slot_reg, slot_next;
    logic [2:0]       step_reg, step_next;
    logic             res_valid_reg, res_valid_next;

    logic accept_px;
    logic emit;
    logic load_out;

    assign pixel_stall  = (state_reg != S_IDLE);
    assign accept_px    = pixel_valid && !pixel_stall;
    assign load_out     = (state_reg == S_OUT) && (!res_valid_reg || !result_stall);
    assign result_valid = res_valid_reg;

    // ---------------- memories ----------------
    logic [LSAW-1:0]  ls_addr;
    logic [23:0]      ls_rd;
    logic [3*CSW-1:0] cs_rd;
    logic [3*CSW-1:0] cs_wr;
    logic             ls_we;

    assign ls_addr = LSAW'(32'(slot_reg) * MAX_WIDTH + 32'(x_reg));
    assign ls_we   = (state_reg == S_READ) && (span != '0);

    logic [23:0] pix_reg;

    bbmf_ram #(.WIDTH(24), .DEPTH(LSD)) u_line_store (
        .clk     (clk),
        .wr_en   (ls_we),
        .wr_addr (ls_addr),
        .wr_data (pix_reg),
        .rd_en   (accept_px),
        .rd_addr (ls_addr),
        .rd_data (ls_rd)
    );

    bbmf_ram #(.WIDTH(3 * CSW), .DEPTH(MAX_WIDTH)) u_column_sums (
        .clk     (clk),
        .wr_en   (state_reg == S_READ),
        .wr_addr (x_reg),
        .wr_data (cs_wr),
        .rd_en   (accept_px),
        .rd_addr (x_reg),
        .rd_data (cs_rd)
    );

    // ---------------- read-modify-write datapath ----------------
    logic [CSW-1:0] ring_reg [RING][3];
    logic [WSW-1:0] ws_reg [3];
    logic [CSW-1:0] cw    [3];
    logic [WSW-1:0] ws_nx [3];

    logic y_has_old;

    assign y_has_old = (span != '0) && (32'(y_reg) >= 32'(span));

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [7:0]     chv;
            logic [7:0]     oldv;
            logic [CSW-1:0] prev;
            logic [CSW-1:0] gone;
            chv   = pix_reg[23 - 8 * c -: 8];
            oldv  = y_has_old ? ls_rd[23 - 8 * c -: 8] : 8'd0;
            prev  = (y_reg == '0) ? '0 : cs_rd[c * CSW +: CSW];
            cw[c] = prev + CSW'(chv);
            cs_wr[c * CSW +: CSW] = (span != '0) ? (cw[c] - CSW'(oldv)) : '0;
            gone  = (32'(x_reg) >= 32'(n_val)) ? ring_reg[rs_reg][c] : '0;
            if (x_reg == '0)
                ws_nx[c] = WSW'(cw[c]);
            else
                ws_nx[c] = ws_reg[c] + WSW'(cw[c]) - WSW'(gone);
        end
    end

    // centre test and last-of-frame mark
    logic [15:0] k16, n16, xx, yy, ww, hh;

    assign k16 = 16'(k_eff);
    assign n16 = 16'(n_val);
    assign xx  = 16'(x_reg);
    assign yy  = 16'(y_reg);
    assign ww  = 16'(w_eff);
    assign hh  = 16'(h_eff);

    assign emit = (xx >= 16'(3) * k16 + 16'd1) && (xx + k16 + 16'd1 < ww)
               && (yy >= 16'(3) * k16 + 16'd1) && (yy + k16 + 16'd1 < hh);

    // ---------------- divider ----------------
    logic [AW-1:0]      area_reg;
    logic [DW-1:0]      rem_reg [3];
    logic [CHAN_W-1:0]  quo_reg [3];
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic               last_hold_reg;

    always_ff @(posedge clk)
    begin
        if (accept_px)
        begin
            pix_reg <= pixel[23:0];
        end
        if (state_reg == S_READ)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ring_reg[rs_reg][c] <= cw[c];
                ws_reg[c]           <= ws_nx[c];
                rem_reg[c]          <= DW'(ws_nx[c]);
            end
            area_reg      <= AW'(n_val) * AW'(n_val);
            cx_reg        <= COORD_W'(xx - k16);
            cy_reg        <= COORD_W'(yy - k16);
            last_hold_reg <= (xx - k16 + n16 + 16'd1 == ww) && (yy - k16 + n16 + 16'd1 == hh);
        end
        if (state_reg == S_DIV)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [DW-1:0] trial;
                trial = DW'(area_reg) << step_reg;
                if (rem_reg[c] >= trial)
                begin
                    rem_reg[c] <= rem_reg[c] - trial;
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b0};
                end
            end
        end
        if (load_out)
        begin
            red_mean   <= quo_reg[0];
            green_mean <= quo_reg[1];
            blue_mean  <= quo_reg[2];
            center_x   <= cx_reg;
            center_y   <= cy_reg;
            last       <= last_hold_reg;
        end
    end

    // ---------------- sequencer and position counters ----------------
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rs_next        = rs_reg;
        slot_next      = slot_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_px)
                    state_next = S_READ;
            end
            S_READ:
            begin
                // advance the raster position
                if (32'(x_reg) + 1 >= 32'(w_eff))
                begin
                    x_next  = '0;
                    rs_next = '0;
                    if (32'(y_reg) + 1 >= 32'(h_eff))
                    begin
                        y_next    = '0;
                        slot_next = '0;
                    end
                    else
                    begin
                        y_next = y_reg + YW'(1);
                        if (span == '0 || 32'(slot_reg) + 1 >= 32'(span))
                            slot_next = '0;
                        else
                            slot_next = slot_reg + SLOTW'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                    if (32'(rs_reg) + 1 >= 32'(n_val))
                        rs_next = '0;
                    else
                        rs_next = rs_reg + RSW'(1);
                end
                step_next  = 3'd7;
                state_next = emit ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (load_out)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // restart the frame on any valid register write
        if (cfg_hit)
        begin
            x_next    = '0;
            y_next    = '0;
            rs_next   = '0;
            slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            rs_reg        <= '0;
            slot_reg      <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            rs_reg        <= rs_next;
            slot_reg      <= slot_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------- assertions ----------------
    a_read_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(state_reg) == S_IDLE)
        else $error("read-modify-write cycle not preceded by the read cycle");

    a_ring_slot: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rs_reg) < 32'(n_val))
        else $error("column ring slot beyond the window width");

    a_row_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (span == '0 && slot_reg == '0) || (span != '0 && 32'(slot_reg) < 32'(span)))
        else $error("line store row slot beyond the stored rows");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && res_valid_reg && result_stall |=> state_reg == S_OUT)
        else $error("pending result overwritten");

endmodule
`default_nettype wire
